FILE: design/tacs_pkg.sv
// ----------------------------------------------------------------------------
// tacs_pkg
// Types and codes shared by the tiny accumulator processor step core.
// ----------------------------------------------------------------------------
package tacs_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_ACCESS  = 2'd3;

    localparam logic [7:0] OPC_HLT  = 8'h00;
    localparam logic [7:0] OPC_LOAD = 8'h01;
    localparam logic [7:0] OPC_MOV  = 8'h04;
    localparam logic [7:0] OPC_ADD  = 8'h08;
    localparam logic [7:0] OPC_SUB  = 8'h11;
    localparam logic [7:0] OPC_JGZ  = 8'h23;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_W    = 32;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] address;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         pc_after;
        logic signed [31:0] acc_value;
        logic               reg_written;
        logic [2:0]         reg_index;
        logic signed [31:0] reg_value;
    } t_result;

endpackage

FILE: design/tacs_ram.sv
// ----------------------------------------------------------------------------
// tacs_ram
// Generic synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tiny_accumulator_cpu_step_core.sv
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step_core
// A write, and an execute while halted, are reported straight from S_IDLE;
// a register read passes through S_RDREG, and an execute through S_OPC, S_B1
// and S_B2, bound by three program memory reads. One item is in flight at a time.
// Synchronous reset clears PC, accumulator, halt flag and the valid bits of
// both memories; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu_step_core
    import tacs_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int RW = $clog2(NUM_REGS);
    localparam logic [12:0] DEPTH_W = 13'(MEM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPC,
        S_B1,
        S_B2,
        S_RDREG
    } t_state;

    // reduce an address below 16*MEM_DEPTH modulo MEM_DEPTH
    function automatic logic [7:0] f_wrap(input logic [8:0] v);
        logic [12:0] t;
        t = {4'd0, v};
        for (int k = 3; k >= 0; k--) begin
            if (t >= (DEPTH_W << k)) begin
                t = t - (DEPTH_W << k);
            end
        end
        return t[7:0];
    endfunction

    t_state                 r_state;
    logic [7:0]             r_pc;
    logic [REG_W-1:0]       r_acc;
    logic                   r_halted;
    logic [MEM_DEPTH-1:0]   r_mvalid;
    logic [NUM_REGS-1:0]    r_rvalid;
    logic                   r_mv;
    logic                   r_rva;
    logic                   r_rvb;
    logic [7:0]             r_opc;
    logic [7:0]             r_b1;
    logic [RW-1:0]          r_ridx;
    logic                   r_done;
    t_result                r_result;

    logic                   accept;
    logic                   mem_we;
    logic [7:0]             waddr_wrap;
    logic [7:0]             raddr_wrap;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [7:0]             mem_rdata;
    logic [7:0]             mbyte;
    logic [RW-1:0]          ra_addr;
    logic [RW-1:0]          rb_addr;
    logic [REG_W-1:0]       ra_rdata;
    logic [REG_W-1:0]       rb_rdata;
    logic [REG_W-1:0]       rega;
    logic [REG_W-1:0]       regb;

    logic [1:0]             x_status;
    logic [7:0]             x_pc;
    logic [REG_W-1:0]       x_acc;
    logic                   x_halt;
    logic                   x_wr;
    logic [RW-1:0]          x_idx;
    logic [REG_W-1:0]       x_val;
    logic                   reg_we;

    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign mem_we     = accept && (i_cmd.operation == OP_WRITE);
    assign waddr_wrap = f_wrap({1'b0, i_cmd.address});
    assign mem_waddr  = waddr_wrap[AW-1:0];
    assign mbyte      = r_mv ? mem_rdata : 8'd0;
    assign rega       = r_rva ? ra_rdata : '0;
    assign regb       = r_rvb ? rb_rdata : '0;
    assign reg_we     = (r_state == S_B2) && x_wr;

    always_comb begin
        unique case (r_state)
            S_OPC:   raddr_wrap = f_wrap({1'b0, r_pc} + 9'd1);
            S_B1:    raddr_wrap = f_wrap({1'b0, r_pc} + 9'd2);
            default: raddr_wrap = r_pc;
        endcase
        mem_raddr = raddr_wrap[AW-1:0];
        if (r_state == S_B1) begin
            ra_addr = mbyte[2:0];
            rb_addr = mbyte[5:3];
        end else begin
            ra_addr = i_cmd.address[2:0];
            rb_addr = i_cmd.address[2:0];
        end
    end

    // instruction execution, valid in S_B2 (operand byte 2 on mbyte)
    always_comb begin
        x_status = ST_EXEC;
        x_pc     = r_pc;
        x_acc    = r_acc;
        x_halt   = 1'b0;
        x_wr     = 1'b0;
        x_idx    = '0;
        x_val    = '0;
        unique case (r_opc)
            OPC_HLT: begin
                x_halt   = 1'b1;
                x_status = ST_HALTED;
            end
            OPC_LOAD: begin
                x_wr  = 1'b1;
                x_idx = r_b1[2:0];
                x_val = {24'd0, mbyte};
                x_pc  = f_wrap({1'b0, r_pc} + 9'd3);
            end
            OPC_MOV: begin
                x_wr  = 1'b1;
                x_idx = r_b1[5:3];
                x_val = rega;
                x_pc  = f_wrap({1'b0, r_pc} + 9'd2);
            end
            OPC_ADD: begin
                x_wr  = 1'b1;
                x_idx = r_b1[5:3];
                x_val = regb + rega;
                x_acc = regb + rega;
                x_pc  = f_wrap({1'b0, r_pc} + 9'd2);
            end
            OPC_SUB: begin
                x_wr  = 1'b1;
                x_idx = r_b1[2:0];
                x_val = rega - {24'd0, mbyte};
                x_acc = rega - {24'd0, mbyte};
                x_pc  = f_wrap({1'b0, r_pc} + 9'd3);
            end
            OPC_JGZ: begin
                if ((r_acc != '0) && !r_acc[REG_W-1]) begin
                    x_pc = f_wrap({1'b0, r_b1});
                end else begin
                    x_pc = f_wrap({1'b0, r_pc} + 9'd2);
                end
            end
            default: begin
                x_status = ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_acc    <= '0;
            r_halted <= 1'b0;
            r_mvalid <= '0;
            r_rvalid <= '0;
            r_mv     <= 1'b0;
            r_rva    <= 1'b0;
            r_rvb    <= 1'b0;
            r_opc    <= '0;
            r_b1     <= '0;
            r_ridx   <= '0;
            r_done   <= 1'b0;
            r_result <= '0;
        end else begin
            r_done <= 1'b0;
            r_mv   <= r_mvalid[mem_raddr];
            r_rva  <= r_rvalid[ra_addr];
            r_rvb  <= r_rvalid[rb_addr];
            if (mem_we) begin
                r_mvalid[mem_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_result <= '{
                            status:    ((i_cmd.operation == OP_EXEC) && r_halted) ?
                                       ST_HALTED : ST_ACCESS,
                            pc_after:  r_pc,
                            acc_value: r_acc,
                            default:   '0
                        };
                        r_ridx   <= i_cmd.address[2:0];
                        unique case (i_cmd.operation)
                            OP_EXEC: begin
                                if (r_halted) begin
                                    r_done  <= 1'b1;
                                end else begin
                                    r_state <= S_OPC;
                                end
                            end
                            OP_READ: begin
                                r_state <= S_RDREG;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_OPC: begin
                    r_opc   <= mbyte;
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_b1    <= mbyte;
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_pc     <= x_pc;
                    r_acc    <= x_acc;
                    r_halted <= r_halted | x_halt;
                    if (x_wr) begin
                        r_rvalid[x_idx] <= 1'b1;
                    end
                    r_result.status      <= x_status;
                    r_result.pc_after    <= x_pc;
                    r_result.acc_value   <= x_acc;
                    r_result.reg_written <= x_wr;
                    r_result.reg_index   <= x_idx;
                    r_result.reg_value   <= x_val;
                    r_done               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_RDREG: begin
                    r_result.reg_index <= r_ridx;
                    r_result.reg_value <= rega;
                    r_done             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    tacs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_prog_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // two copies of the register file give the source and destination reads
    tacs_ram #(
        .WIDTH (REG_W),
        .DEPTH (NUM_REGS)
    ) u_regs_a (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (x_idx),
        .i_wdata (x_val),
        .i_raddr (ra_addr),
        .o_rdata (ra_rdata)
    );

    tacs_ram #(
        .WIDTH (REG_W),
        .DEPTH (NUM_REGS)
    ) u_regs_b (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (x_idx),
        .i_wdata (x_val),
        .i_raddr (rb_addr),
        .o_rdata (rb_rdata)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: design/tacs_chk.sv
// ----------------------------------------------------------------------------
// tacs_chk
// Port-level checks for the tiny accumulator processor step core.
// ----------------------------------------------------------------------------
module tacs_chk
    import tacs_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_cmd    i_cmd,
    input logic    o_done,
    input t_result o_result
);

    a_write_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.operation == OP_WRITE)
        |=> o_done && (o_result.status == ST_ACCESS))
        else $error("memory write transfer not reported next cycle");

    a_read_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.operation == OP_READ)
        |=> busy ##1 (o_done && !busy))
        else $error("register read result timing wrong");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result issued while still busy");

    a_wr_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.reg_written |-> (o_result.status == ST_EXEC))
        else $error("register write flagged on non-executed item");

endmodule

bind tiny_accumulator_cpu_step_core tacs_chk u_tacs_chk (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tiny_accumulator_cpu_step_core. A shadow copy of the
// program memory, register file, PC, accumulator and halt flag predicts every
// result. Directed items cover the reset state, each opcode and an unknown
// opcode. Random programs with random operands follow, built at the
// current PC, with noise mixed in. The halt state is tried last, because
// only reset leaves it.
// ----------------------------------------------------------------------------
module testbench;
    import tacs_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    logic [7:0]  shadow_mem [0:255];
    logic [31:0] shadow_regs [0:7];
    logic [7:0]  shadow_pc;
    logic [31:0] shadow_acc;
    logic        shadow_halted;

    t_result     step_results [$];
    t_result     want;
    int unsigned fail_count  = 0;
    int unsigned n_sent      = 0;
    int unsigned gap_pct     = 0;
    int unsigned idle_cycles = 0;

    tiny_accumulator_cpu_step_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result cpu_step(input t_cmd c);
        t_result    r;
        logic [7:0] a1, a2, opc, b1, b2;
        logic [2:0] d, s;
        r = '0;
        r.status = ST_ACCESS;
        case (c.operation)
            OP_WRITE: shadow_mem[c.address] = c.data;
            OP_READ: begin
                r.reg_index = c.address[2:0];
                r.reg_value = shadow_regs[c.address[2:0]];
            end
            OP_EXEC: begin
                if (shadow_halted) begin
                    r.status = ST_HALTED;
                end else begin
                    a1  = shadow_pc + 8'd1;
                    a2  = shadow_pc + 8'd2;
                    opc = shadow_mem[shadow_pc];
                    b1  = shadow_mem[a1];
                    b2  = shadow_mem[a2];
                    d   = b1[5:3];
                    s   = b1[2:0];
                    r.status = ST_EXEC;
                    case (opc)
                        OPC_HLT: begin
                            shadow_halted = 1'b1;
                            r.status = ST_HALTED;
                        end
                        OPC_LOAD: begin
                            shadow_regs[s] = {24'd0, b2};
                            r.reg_written = 1'b1;
                            r.reg_index = s;
                            r.reg_value = shadow_regs[s];
                            shadow_pc = shadow_pc + 8'd3;
                        end
                        OPC_MOV: begin
                            shadow_regs[d] = shadow_regs[s];
                            r.reg_written = 1'b1;
                            r.reg_index = d;
                            r.reg_value = shadow_regs[d];
                            shadow_pc = shadow_pc + 8'd2;
                        end
                        OPC_ADD: begin
                            shadow_regs[d] = shadow_regs[d] + shadow_regs[s];
                            shadow_acc = shadow_regs[d];
                            r.reg_written = 1'b1;
                            r.reg_index = d;
                            r.reg_value = shadow_regs[d];
                            shadow_pc = shadow_pc + 8'd2;
                        end
                        OPC_SUB: begin
                            shadow_regs[s] = shadow_regs[s] - {24'd0, b2};
                            shadow_acc = shadow_regs[s];
                            r.reg_written = 1'b1;
                            r.reg_index = s;
                            r.reg_value = shadow_regs[s];
                            shadow_pc = shadow_pc + 8'd3;
                        end
                        OPC_JGZ: begin
                            if (shadow_acc != 32'd0 && !shadow_acc[31]) begin
                                shadow_pc = b1;
                            end else begin
                                shadow_pc = shadow_pc + 8'd2;
                            end
                        end
                        default: r.status = ST_UNKNOWN;
                    endcase
                end
            end
            default: ;
        endcase
        r.pc_after  = shadow_pc;
        r.acc_value = shadow_acc;
        return r;
    endfunction

    task automatic note_failure(input string what, input t_result w, input t_result g);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s: want st=%0d pc=%h acc=%h wr=%0d idx=%0d val=%h",
                     what, w.status, w.pc_after, w.acc_value, w.reg_written,
                     w.reg_index, w.reg_value);
            $display("%s:  got st=%0d pc=%h acc=%h wr=%0d idx=%0d val=%h",
                     what, g.status, g.pc_after, g.acc_value, g.reg_written,
                     g.reg_index, g.reg_value);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (step_results.size() == 0) begin
                note_failure("unexpected result", '0, o_result);
            end else begin
                want = step_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.pc_after !== want.pc_after ||
                    o_result.acc_value !== want.acc_value ||
                    o_result.reg_written !== want.reg_written ||
                    o_result.reg_index !== want.reg_index ||
                    o_result.reg_value !== want.reg_value) begin
                    note_failure("mismatch", want, o_result);
                end
            end
        end
    end

    // watchdog: no transfer in either direction for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] data);
        t_cmd c;
        c.operation = op;
        c.address   = addr;
        c.data      = data;
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        step_results.push_back(cpu_step(c));
        n_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (step_results.size() != 0) @(posedge i_clk);
    endtask

    // lay an instruction down at the current PC and execute it, unless a stale halt
    // is left there; a broken sequence drops some of its bytes, leaving stale memory in their place
    task automatic run_instr(input logic [7:0] opc, input logic [7:0] b1,
                             input logic [7:0] b2, input bit broken);
        logic [7:0]  base;
        int unsigned len;
        base = shadow_pc;
        case (opc)
            OPC_LOAD, OPC_SUB:         len = 3;
            OPC_MOV, OPC_ADD, OPC_JGZ: len = 2;
            default:                   len = 1;
        endcase
        if (!broken || $urandom_range(1)) send_cmd(OP_WRITE, base, opc);
        if (len > 1 && (!broken || $urandom_range(1)))
            send_cmd(OP_WRITE, base + 8'd1, b1);
        if (len > 2 && (!broken || $urandom_range(1)))
            send_cmd(OP_WRITE, base + 8'd2, b2);
        if (opc == OPC_HLT || shadow_mem[shadow_pc] != OPC_HLT)
            send_cmd(OP_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic test_idle_ops();
        send_cmd(OP_READ, 8'h00, 8'h00);
        send_cmd(OP_NONE, 8'hFF, 8'hFF);
    endtask

    task automatic test_instruction_set();
        run_instr(OPC_LOAD, 8'hFF, 8'hFF, 1'b0);
        run_instr(OPC_SUB,  8'h00, 8'h01, 1'b0);
        run_instr(OPC_JGZ,  8'h80, 8'h00, 1'b0);
        run_instr(OPC_MOV,  8'h37, 8'h00, 1'b0);
        run_instr(OPC_ADD,  8'h3F, 8'h00, 1'b0);
        run_instr(OPC_JGZ,  8'hFF, 8'h00, 1'b0);
        // a second load and an unknown opcode follow
        run_instr(OPC_LOAD, 8'h00, 8'h00, 1'b0);
        run_instr(8'hFF,    8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_random_programs(input int unsigned pct, input int unsigned count);
        int unsigned target, mid, r;
        logic [7:0]  opc;
        bit          paused;
        gap_pct = pct;
        target  = n_sent + count;
        mid     = n_sent + count / 2;
        paused  = 1'b0;
        while (n_sent < target) begin
            if (!paused && n_sent >= mid) begin
                drain_results();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 75) begin
                case ($urandom_range(5))
                    0:       opc = OPC_LOAD;
                    1:       opc = OPC_MOV;
                    2:       opc = OPC_ADD;
                    3:       opc = OPC_SUB;
                    4:       opc = OPC_JGZ;
                    default: opc = 8'($urandom_range(255, 1));
                endcase
                run_instr(opc, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          $urandom_range(9) == 0);
            end else if (r < 85) begin
                send_cmd(OP_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (r < 92) begin
                send_cmd(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (r < 96) begin
                send_cmd(OP_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (shadow_mem[shadow_pc] != OPC_HLT) begin
                send_cmd(OP_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
                send_cmd(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_halt_state();
        gap_pct = 0;
        run_instr(OPC_HLT, 8'h00, 8'h00, 1'b0);
        send_cmd(OP_EXEC, 8'hFF, 8'hFF);
        send_cmd(OP_WRITE, shadow_pc, OPC_LOAD);
        send_cmd(OP_READ, 8'h07, 8'h00);
        send_cmd(OP_NONE, 8'h00, 8'h00);
        send_cmd(OP_EXEC, 8'h00, 8'h00);
    endtask

    initial begin
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_pc     = '0;
        shadow_acc    = '0;
        shadow_halted = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ops();
        test_instruction_set();
        drain_results();
        test_random_programs(32, 400);
        test_random_programs(61, 400);
        test_random_programs(0, 400);
        test_halt_state();

        start <= 1'b0;
        for (int i = 0; i < 1000 && step_results.size() != 0; i++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (step_results.size() != 0) begin
            note_failure("missing result", step_results.pop_front(), '0);
        end

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
